// File: src/clcd_pkg.sv
// Shared types and constants for the character LCD text console.
// No dependencies; every other file of the block but clcd_ifs imports this package.
package clcd_pkg;

  // Input operation codes.
  typedef enum logic [1:0] {
    MODE_PRINT      = 2'd0,
    MODE_SET_CURSOR = 2'd1,
    MODE_CLEAR      = 2'd2
  } mode_t;

  // Controller bytes and character codes.
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ROW_EVEN = 8'h80;
  localparam logic [7:0] CMD_ROW_ODD  = 8'hC0;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Bytes kept per input item; further bytes are dropped.
  localparam int MAX_RESULTS = 20;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // One step of the sequencer as seen by the output stage.
  typedef struct packed {
    logic       valid;     // a byte is produced in this step
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       fin;       // the item is complete after this step
  } gen_t;

endpackage

// File: src/clcd_ifs.sv
// Handshake interfaces for the input and result channels of the console.
// Depends on nothing; widths follow the fixed field widths of the block.
interface clcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  logic [2:0] row;
  logic [4:0] col;

  modport source (output valid, output mode, output char_code, output row,
                  output col, input ready);
  modport sink (input valid, input mode, input char_code, input row,
                input col, output ready);
endinterface

interface clcd_out_if;
  logic       valid;
  logic       ready;
  logic       is_data;
  logic [7:0] lcd_byte;
  logic       last;

  modport source (output valid, output is_data, output lcd_byte, output last,
                  input ready);
  modport sink (input valid, input is_data, input lcd_byte, input last,
                output ready);
endinterface

// File: src/clcd_addr.sv
// Cursor address unit: forms the set-DDRAM-address command for a row/column.
// Depends on clcd_pkg for the command base bytes.
module clcd_addr
  import clcd_pkg::*;
#(
  parameter int LINE_WIDTH = 20,
  parameter int COL_W      = 5
) (
  input  logic [2:0]       row,
  input  logic [COL_W-1:0] col,
  output logic [7:0]       cmd
);

  logic [7:0] base;
  logic [7:0] offset;

  // Odd rows sit in the second controller line, even rows in the first.
  assign base = row[0] ? CMD_ROW_ODD : CMD_ROW_EVEN;

  // Each row pair shifts the address by one line width.
  always_comb begin
    case (row[2:1])
      2'd0:    offset = 8'd0;
      2'd1:    offset = 8'(LINE_WIDTH);
      default: offset = 8'(2 * LINE_WIDTH);
    endcase
  end

  // The sum wraps modulo 256.
  assign cmd = base + offset + 8'(col);

endmodule

// File: src/clcd_seq.sv
// Console sequencer: keeps the cursor and steps out one controller byte per
// step. Depends on clcd_pkg and the shared address unit clcd_addr.
module clcd_seq
  import clcd_pkg::*;
#(
  parameter int LINE_WIDTH = 20,
  parameter int LINE_COUNT = 4,
  parameter int TAB_STOP   = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_row,
  input  logic [4:0] in_col,
  input  logic       step_ok,
  output gen_t       gen
);

  localparam int COL_W = $clog2(LINE_WIDTH + 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_PREP = 10'b00_0000_0010,
    S_HOME = 10'b00_0000_0100,
    S_WRAP = 10'b00_0000_1000,
    S_BODY = 10'b00_0001_0000,
    S_PAD  = 10'b00_0010_0000,
    S_NLMV = 10'b00_0100_0000,
    S_SETC = 10'b00_1000_0000,
    S_CLR  = 10'b01_0000_0000,
    S_SPARE = 10'b10_0000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [2:0]           row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [COL_W-1:0]     pad_r, pad_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]           char_r;
  logic [2:0]           srow_r;
  logic [COL_W-1:0]     scol_r;

  logic                 load;
  logic                 emit;
  logic                 is_data;
  logic [7:0]           byte_val;
  logic                 fin;
  logic                 room;
  logic [2:0]           a_row;
  logic [COL_W-1:0]     a_col;
  logic [7:0]           a_cmd;
  logic [2:0]           row_inc;
  logic [COL_W-1:0]     col_inc;
  logic [COL_W-1:0]     pad_inc;
  logic [2:0]           in_row_sat;
  logic [COL_W-1:0]     in_col_sat;
  logic [LINE_WIDTH:0]  tab_stop;

  // Columns that are tab stops, settled at elaboration.
  for (genvar i = 0; i <= LINE_WIDTH; i++) begin : g_tab
    assign tab_stop[i] = ((i % TAB_STOP) == 0);
  end

  // Shared address unit used by every cursor move.
  clcd_addr #(
    .LINE_WIDTH (LINE_WIDTH),
    .COL_W      (COL_W)
  ) u_addr (
    .row (a_row),
    .col (a_col),
    .cmd (a_cmd)
  );

  assign row_inc = row_r + 3'd1;
  assign col_inc = col_r + COL_W'(1);
  assign pad_inc = pad_r + COL_W'(1);
  assign room    = (cnt_r < RES_CNT_W'(MAX_RESULTS));

  // A set-cursor request saturates to the display edges.
  assign in_row_sat = (in_row > 3'(LINE_COUNT)) ? 3'(LINE_COUNT) : in_row;
  assign in_col_sat = ({1'b0, in_col} > 6'(LINE_WIDTH)) ? COL_W'(LINE_WIDTH)
                                                        : COL_W'(in_col);

  // Step logic: each state issues at most one byte per step.
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    pad_nxt   = pad_r;
    load      = 1'b0;
    emit      = 1'b0;
    is_data   = 1'b0;
    byte_val  = CMD_CLEAR;
    fin       = 1'b0;
    a_row     = row_inc;
    a_col     = '0;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          load = 1'b1;
          case (in_mode)
            MODE_PRINT:      state_nxt = S_PREP;
            MODE_SET_CURSOR: state_nxt = S_SETC;
            MODE_CLEAR:      state_nxt = S_CLR;
            default:         state_nxt = S_IDLE;
          endcase
        end
      end
      S_PREP: begin
        if (step_ok) begin
          if (row_r >= 3'(LINE_COUNT)) begin
            emit      = 1'b1;
            byte_val  = CMD_CLEAR;
            state_nxt = S_HOME;
          end else if (col_r >= COL_W'(LINE_WIDTH)) begin
            state_nxt = S_WRAP;
          end else begin
            state_nxt = S_BODY;
          end
        end
      end
      S_HOME: begin
        if (step_ok) begin
          a_row     = 3'd0;
          emit      = 1'b1;
          byte_val  = a_cmd;
          row_nxt   = 3'd0;
          col_nxt   = '0;
          state_nxt = S_BODY;
        end
      end
      S_WRAP: begin
        if (step_ok) begin
          emit      = 1'b1;
          byte_val  = a_cmd;
          row_nxt   = row_inc;
          col_nxt   = '0;
          state_nxt = S_BODY;
        end
      end
      S_BODY: begin
        if (step_ok) begin
          if (char_r == CH_NEWLINE) begin
            if (col_r == '0) begin
              fin       = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              emit      = 1'b1;
              is_data   = 1'b1;
              byte_val  = CH_SPACE;
              pad_nxt   = col_inc;
              state_nxt = (col_inc == COL_W'(LINE_WIDTH)) ? S_NLMV : S_PAD;
            end
          end else if (char_r == CH_TAB) begin
            emit     = 1'b1;
            is_data  = 1'b1;
            byte_val = CH_SPACE;
            col_nxt  = col_inc;
            if (tab_stop[col_inc]) begin
              fin       = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_PREP;
            end
          end else begin
            emit      = 1'b1;
            is_data   = 1'b1;
            byte_val  = char_r;
            col_nxt   = col_inc;
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_PAD: begin
        if (step_ok) begin
          emit     = 1'b1;
          is_data  = 1'b1;
          byte_val = CH_SPACE;
          pad_nxt  = pad_inc;
          if (pad_inc == COL_W'(LINE_WIDTH)) begin
            state_nxt = S_NLMV;
          end
        end
      end
      S_NLMV: begin
        if (step_ok) begin
          emit      = 1'b1;
          byte_val  = a_cmd;
          row_nxt   = row_inc;
          col_nxt   = '0;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SETC: begin
        if (step_ok) begin
          a_row     = srow_r;
          a_col     = scol_r;
          emit      = 1'b1;
          byte_val  = a_cmd;
          row_nxt   = srow_r;
          col_nxt   = scol_r;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLR: begin
        if (step_ok) begin
          emit      = 1'b1;
          byte_val  = CMD_CLEAR;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Bytes past the per-item limit are dropped; the cursor still moves.
  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = '0;
    end else if (emit && room) begin
      cnt_nxt = cnt_r + RES_CNT_W'(1);
    end
  end

  assign gen.valid    = emit && room;
  assign gen.is_data  = is_data;
  assign gen.lcd_byte = byte_val;
  assign gen.fin      = fin;

  // Control state and cursor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      row_r   <= 3'd0;
      col_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Item payload and pad counter.
  always_ff @(posedge clk) begin
    pad_r <= pad_nxt;
    if (load) begin
      char_r <= in_char_code;
      srow_r <= in_row_sat;
      scol_r <= in_col_sat;
    end
  end

endmodule

// File: src/clcd_outq.sv
// Output stage: a one-byte hold register that learns whether its byte is the
// last of an item, followed by the result register. Depends on clcd_pkg.
module clcd_outq
  import clcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  gen_t       gen,
  output logic       step_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_data,
  output logic [7:0] out_lcd_byte,
  output logic       out_last
);

  logic       hold_v_r;
  logic       hold_last_r;
  logic       hold_data_r;
  logic [7:0] hold_byte_r;
  logic       out_v_r;
  logic       out_data_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic       out_free;
  logic       flush;

  // The sequencer may step only when the hold register is empty or its byte can move on.
  assign out_free = !out_v_r || out_ready;
  assign step_ok  = !hold_v_r || out_free;
  assign flush    = hold_v_r && out_free && (hold_last_r || gen.valid || gen.fin);

  // Valid flags of both registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (gen.valid) begin
        hold_v_r <= 1'b1;
      end else if (flush) begin
        hold_v_r <= 1'b0;
      end
      if (flush) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload moves from the sequencer to hold and from hold to the output.
  always_ff @(posedge clk) begin
    if (gen.valid) begin
      hold_data_r <= gen.is_data;
      hold_byte_r <= gen.lcd_byte;
      hold_last_r <= gen.fin;
    end
    if (flush) begin
      out_data_r <= hold_data_r;
      out_byte_r <= hold_byte_r;
      out_last_r <= hold_last_r || (gen.fin && !gen.valid);
    end
  end

  assign out_valid    = out_v_r;
  assign out_is_data  = out_data_r;
  assign out_lcd_byte = out_byte_r;
  assign out_last     = out_last_r;

endmodule

// File: src/char_lcd_text_console.sv
// Character LCD text console: turns a character stream into controller
// command and data bytes. Depends on clcd_pkg, clcd_ifs, clcd_seq, clcd_outq.
//
// The console takes one request at a time and answers with a burst of
// controller bytes, each flagged as data or command, the final one marked
// last. The sequencer takes a request while idle and checks the cursor
// position before each character or tab space: a newline off column zero
// pads the line with spaces and then moves the cursor, a tab emits spaces
// up to the next tab stop, and clearing and homing or wrapping adds a step.
// The rate is set by the sequencer, which issues at most one byte per cycle
// through a single hold register and the shared cursor address unit; a
// stalled result channel holds the sequencer. Requests are accepted only
// while it is idle.
module char_lcd_text_console
  import clcd_pkg::*;
#(
  parameter int LINE_WIDTH = 20,
  parameter int LINE_COUNT = 4,
  parameter int TAB_STOP   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  clcd_in_if.sink     in_ch,
  clcd_out_if.source  out_ch
);

  gen_t gen;
  logic step_ok;

  // Cursor tracking and byte generation.
  clcd_seq #(
    .LINE_WIDTH (LINE_WIDTH),
    .LINE_COUNT (LINE_COUNT),
    .TAB_STOP   (TAB_STOP)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_mode      (in_ch.mode),
    .in_char_code (in_ch.char_code),
    .in_row       (in_ch.row),
    .in_col       (in_ch.col),
    .step_ok      (step_ok),
    .gen          (gen)
  );

  // Hold and result registers.
  clcd_outq u_outq (
    .clk          (clk),
    .rst_n        (rst_n),
    .gen          (gen),
    .step_ok      (step_ok),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_is_data  (out_ch.is_data),
    .out_lcd_byte (out_ch.lcd_byte),
    .out_last     (out_ch.last)
  );

endmodule

// File: src/clcd_chk.sv
// Port-level checker for the character LCD text console, bound to the top.
// Depends on clcd_pkg for the operation codes.
module clcd_chk
  import clcd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_data,
  input logic [7:0] out_lcd_byte,
  input logic       out_last
);

  // A stalled result stays offered.
  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_is_data) && $stable(out_lcd_byte) && $stable(out_last))
    else $error("result payload changed while stalled");

  // A real request keeps the console busy for at least the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
      (in_mode == MODE_PRINT || in_mode == MODE_SET_CURSOR || in_mode == MODE_CLEAR)
      |=> !in_ready)
    else $error("request accepted while a previous one is at work");

  // Reset leaves no result pending.
  a_reset_empty : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind char_lcd_text_console clcd_chk u_clcd_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_mode      (in_ch.mode),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_is_data  (out_ch.is_data),
  .out_lcd_byte (out_ch.lcd_byte),
  .out_last     (out_ch.last)
);

// File: tb/tb_char_lcd_text_console.sv
`timescale 1ns / 100ps
// Self-checking testbench for the character LCD text console.
// Depends on clcd_pkg, the clcd_in_if / clcd_out_if interfaces and the console RTL.
module tb_char_lcd_text_console;
  import clcd_pkg::*;

  localparam int LINE_WIDTH  = 20;
  localparam int LINE_COUNT  = 4;
  localparam int TAB_STOP    = 4;
  localparam int IDLE_MAX    = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 60;

  // Mode 3 has no member in the package; the console ignores it.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
    logic       last;
  } lcd_word_t;

  // One request for the console, with an optional hand-written answer.
  typedef struct {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [2:0] row;
    logic [4:0] col;
    bit         fixed;
    int         fixed_n;
    lcd_word_t  fixed_word;
  } console_req_t;

  logic clk;
  logic rst_n;

  clcd_in_if  in_ch ();
  clcd_out_if out_ch ();

  char_lcd_text_console #(
    .LINE_WIDTH (LINE_WIDTH),
    .LINE_COUNT (LINE_COUNT),
    .TAB_STOP   (TAB_STOP)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predicted cursor position and the bytes still owed by the console.
  logic [2:0]   cur_row;
  logic [4:0]   cur_col;
  lcd_word_t    lcd_burst[$];
  lcd_word_t    pending_lcd_bytes[$];
  console_req_t req_on_bus;
  lcd_word_t    want;

  int mismatches;
  int requests_taken;
  int bytes_checked;
  int newlines_seen;
  int tabs_seen;
  int wraps_seen;
  int homes_seen;
  int quiet_cycles;
  int out_stall_max;

  // Set-DDRAM-address command for a row and column.
  function automatic logic [7:0] lcd_cursor_cmd(int r, int c);
    int addr;
    if (r % 2 == 1) begin
      addr = CMD_ROW_ODD + ((r - 1) / 2) * LINE_WIDTH + c;
    end else begin
      addr = CMD_ROW_EVEN + (r / 2) * LINE_WIDTH + c;
    end
    return addr[7:0];
  endfunction

  // Bytes beyond the per-request limit are dropped.
  function automatic void stage_byte(logic d, logic [7:0] b);
    lcd_word_t w;
    w.is_data  = d;
    w.lcd_byte = b;
    w.last     = 1'b0;
    if (lcd_burst.size() < MAX_RESULTS) begin
      lcd_burst.push_back(w);
    end
  endfunction

  function automatic void move_cursor_to(int r, int c);
    cur_row = 3'(r);
    cur_col = 5'(c);
    stage_byte(1'b0, lcd_cursor_cmd(r, c));
  endfunction

  // Clear and home once past the last line, then wrap a full line.
  function automatic void settle_position();
    if (cur_row >= LINE_COUNT) begin
      homes_seen++;
      stage_byte(1'b0, CMD_CLEAR);
      move_cursor_to(0, 0);
    end
    if (cur_col >= LINE_WIDTH) begin
      wraps_seen++;
      move_cursor_to(cur_row + 1, 0);
    end
  endfunction

  function automatic void advance_glyph(logic [7:0] b);
    cur_col = cur_col + 1'b1;
    stage_byte(1'b1, b);
  endfunction

  function automatic void emit_space();
    settle_position();
    advance_glyph(CH_SPACE);
  endfunction

  function automatic void print_char(logic [7:0] ch);
    settle_position();
    if (ch == CH_NEWLINE) begin
      newlines_seen++;
      // A newline at column zero leaves the line alone.
      if (cur_col != 0) begin
        for (int i = cur_col; i < LINE_WIDTH; i++) begin
          stage_byte(1'b1, CH_SPACE);
        end
        move_cursor_to(cur_row + 1, 0);
      end
    end else if (ch == CH_TAB) begin
      tabs_seen++;
      // A tab always moves at least one column.
      if (cur_col % TAB_STOP == 0 && cur_col != LINE_WIDTH) begin
        emit_space();
      end
      while (cur_col % TAB_STOP != 0) begin
        emit_space();
      end
    end else begin
      advance_glyph(ch);
    end
  endfunction

  // Fills lcd_burst with the bytes one request causes and updates the cursor.
  function automatic void console_predict(logic [1:0] mode, logic [7:0] ch,
                                          logic [2:0] r, logic [4:0] c);
    int sat_r;
    int sat_c;
    lcd_burst.delete();
    case (mode)
      MODE_PRINT: begin
        print_char(ch);
      end
      MODE_SET_CURSOR: begin
        sat_r = (r > LINE_COUNT) ? LINE_COUNT : r;
        sat_c = (c > LINE_WIDTH) ? LINE_WIDTH : c;
        move_cursor_to(sat_r, sat_c);
      end
      MODE_CLEAR: begin
        stage_byte(1'b0, CMD_CLEAR);
      end
      default: begin
      end
    endcase
    if (lcd_burst.size() > 0) begin
      lcd_burst[lcd_burst.size() - 1].last = 1'b1;
    end
  endfunction

  // Rows of the directed table.
  function automatic console_req_t fixed_row(logic [1:0] mode, logic [7:0] ch,
                                             logic [2:0] r, logic [4:0] c, int n,
                                             logic d, logic [7:0] b);
    console_req_t q;
    q.mode                = mode;
    q.char_code           = ch;
    q.row                 = r;
    q.col                 = c;
    q.fixed               = 1'b1;
    q.fixed_n             = n;
    q.fixed_word.is_data  = d;
    q.fixed_word.lcd_byte = b;
    q.fixed_word.last     = 1'b1;
    return q;
  endfunction

  function automatic console_req_t model_row(logic [1:0] mode, logic [7:0] ch,
                                             logic [2:0] r, logic [4:0] c);
    console_req_t q;
    q       = fixed_row(mode, ch, r, c, 0, 1'b0, 8'h00);
    q.fixed = 1'b0;
    return q;
  endfunction

  // Predict on every input transfer, then check every output transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_row = '0;
      cur_col = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        requests_taken++;
        console_predict(in_ch.mode, in_ch.char_code, in_ch.row, in_ch.col);
        if (req_on_bus.fixed) begin
          if (req_on_bus.fixed_n > 0) begin
            pending_lcd_bytes.push_back(req_on_bus.fixed_word);
          end
        end else begin
          foreach (lcd_burst[i]) begin
            pending_lcd_bytes.push_back(lcd_burst[i]);
          end
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        bytes_checked++;
        if (pending_lcd_bytes.size() == 0) begin
          $error("lcd_byte: expected nothing, got %02h", out_ch.lcd_byte);
          mismatches++;
        end else begin
          want = pending_lcd_bytes.pop_front();
          if (out_ch.is_data !== want.is_data) begin
            $error("is_data: expected %0d, got %0d", want.is_data, out_ch.is_data);
            mismatches++;
          end
          if (out_ch.lcd_byte !== want.lcd_byte) begin
            $error("lcd_byte: expected %02h, got %02h", want.lcd_byte, out_ch.lcd_byte);
            mismatches++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: the run ends if no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: stall a random number of cycles before each transfer.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Present one request, wait for its transfer, then idle a random gap.
  task automatic send_request(console_req_t q, int gap_max);
    int gap;
    in_ch.mode      <= q.mode;
    in_ch.char_code <= q.char_code;
    in_ch.row       <= q.row;
    in_ch.col       <= q.col;
    in_ch.valid     <= 1'b1;
    req_on_bus      <= q;
    do @(posedge clk); while (!in_ch.ready);
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the input off until every predicted byte has arrived.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_lcd_bytes.size() != 0);
  endtask

  initial begin
    console_req_t directed_rows[$];
    console_req_t q;
    int phase_items[3];
    int phase_gap[3];
    int phase_stall[3];
    int counted;
    int pick;

    phase_items     = '{30, 28, 27};
    phase_gap       = '{16, 0, 3};
    phase_stall     = '{16, 0, 16};
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_PRINT;
    in_ch.char_code = 8'h00;
    in_ch.row       = 3'd0;
    in_ch.col       = 5'd0;
    out_stall_max   = IDLE_MAX;
    req_on_bus      = model_row(MODE_PRINT, 8'h00, 3'd0, 5'd0);

    // Directed table; the cursor starts at row 0, column 0.
    directed_rows.push_back(fixed_row(MODE_PRINT, 8'h41, 3'd0, 5'd0, 1, 1'b1, 8'h41));
    directed_rows.push_back(fixed_row(MODE_PRINT, 8'hFF, 3'd0, 5'd0, 1, 1'b1, 8'hFF));
    directed_rows.push_back(fixed_row(MODE_PRINT, 8'h00, 3'd0, 5'd0, 1, 1'b1, 8'h00));
    directed_rows.push_back(fixed_row(MODE_CLEAR, 8'h00, 3'd0, 5'd0, 1, 1'b0, CMD_CLEAR));
    directed_rows.push_back(fixed_row(MODE_UNUSED, 8'hFF, 3'd7, 5'd31, 0, 1'b0, 8'h00));
    directed_rows.push_back(model_row(MODE_PRINT, CH_NEWLINE, 3'd0, 5'd0));
    directed_rows.push_back(fixed_row(MODE_PRINT, CH_NEWLINE, 3'd0, 5'd0, 0, 1'b0, 8'h00));
    directed_rows.push_back(model_row(MODE_PRINT, CH_TAB, 3'd0, 5'd0));
    directed_rows.push_back(fixed_row(MODE_PRINT, 8'h61, 3'd0, 5'd0, 1, 1'b1, 8'h61));
    directed_rows.push_back(model_row(MODE_PRINT, CH_TAB, 3'd0, 5'd0));
    directed_rows.push_back(fixed_row(MODE_SET_CURSOR, 8'h00, 3'd2, 5'd19, 1, 1'b0, 8'hA7));
    directed_rows.push_back(model_row(MODE_PRINT, CH_TAB, 3'd0, 5'd0));
    directed_rows.push_back(model_row(MODE_PRINT, CH_TAB, 3'd0, 5'd0));
    directed_rows.push_back(fixed_row(MODE_SET_CURSOR, 8'h00, 3'd3, 5'd20, 1, 1'b0, 8'hE8));
    directed_rows.push_back(model_row(MODE_PRINT, 8'h5A, 3'd0, 5'd0));
    directed_rows.push_back(model_row(MODE_PRINT, 8'h71, 3'd0, 5'd0));
    directed_rows.push_back(fixed_row(MODE_SET_CURSOR, 8'h00, 3'd7, 5'd31, 1, 1'b0, 8'hBC));
    directed_rows.push_back(model_row(MODE_PRINT, CH_NEWLINE, 3'd0, 5'd0));
    directed_rows.push_back(fixed_row(MODE_SET_CURSOR, 8'h00, 3'd0, 5'd20, 1, 1'b0, 8'h94));
    directed_rows.push_back(model_row(MODE_PRINT, CH_NEWLINE, 3'd0, 5'd0));
    directed_rows.push_back(fixed_row(MODE_SET_CURSOR, 8'h00, 3'd4, 5'd0, 1, 1'b0, 8'hA8));
    directed_rows.push_back(fixed_row(MODE_CLEAR, 8'h00, 3'd0, 5'd0, 1, 1'b0, CMD_CLEAR));
    directed_rows.push_back(model_row(MODE_PRINT, CH_TAB, 3'd0, 5'd0));
    directed_rows.push_back(fixed_row(MODE_SET_CURSOR, 8'h00, 3'd5, 5'd16, 1, 1'b0, 8'hB8));
    directed_rows.push_back(model_row(MODE_PRINT, 8'h80, 3'd0, 5'd0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i], IDLE_MAX);
    end
    wait_for_drain();

    // Random phases: idling on both sides, none at all, then a busy sender.
    for (int p = 0; p < 3; p++) begin
      out_stall_max = phase_stall[p];
      counted = 0;
      while (counted < phase_items[p]) begin
        q = model_row(MODE_PRINT, 8'h00, 3'd0, 5'd0);
        q.char_code = 8'($urandom_range(0, 255));
        q.row       = 3'($urandom_range(0, 7));
        q.col       = 5'($urandom_range(0, 31));
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
          // Text with plenty of newlines and tabs to drive wraps and clears.
          pick = $urandom_range(0, 99);
          if (pick < 20) begin
            q.char_code = CH_NEWLINE;
          end else if (pick < 32) begin
            q.char_code = CH_TAB;
          end else if (pick < 40) begin
            q.char_code = CH_SPACE;
          end
        end else if (pick < 86) begin
          q.mode = MODE_SET_CURSOR;
          if ($urandom_range(0, 9) != 0) begin
            q.row = 3'($urandom_range(0, LINE_COUNT));
          end
          pick = $urandom_range(0, 99);
          if (pick < 30) begin
            q.col = 5'($urandom_range(LINE_WIDTH - 3, LINE_WIDTH));
          end else if (pick < 90) begin
            q.col = 5'($urandom_range(0, LINE_WIDTH));
          end
        end else if (pick < 96) begin
          q.mode = MODE_CLEAR;
        end else begin
          q.mode = MODE_UNUSED;
        end
        if (q.mode != MODE_UNUSED) begin
          counted++;
        end
        send_request(q, phase_gap[p]);
        if ($urandom_range(0, 19) == 0) begin
          wait_for_drain();
        end
      end
      wait_for_drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d newlines, %0d tabs) and checked %0d display bytes.",
             requests_taken, newlines_seen, tabs_seen, bytes_checked);
    $display("The cursor wrapped %0d times and ran off the last line %0d times.",
             wraps_seen, homes_seen);
    if (mismatches == 0 && pending_lcd_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
